### hw/rtl/tlpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlpt_pkg;

    // Operation codes carried in the op field of an input item.
    localparam logic [1:0] OP_TRANSLATE  = 2'd0;
    localparam logic [1:0] OP_WRITE_DIR  = 2'd1;
    localparam logic [1:0] OP_WRITE_PAGE = 2'd2;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    // Fixed field widths of the item formats.
    localparam int VA_W       = 32;
    localparam int PA_W       = 32;
    localparam int INDEX_W    = 10;
    localparam int SLOT_W     = 2;
    localparam int FRAME_W    = 20;

    // Entries of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_DIR_FAULT  = 2'd1,
        ST_PAGE_FAULT = 2'd2,
        ST_PROT_FAULT = 2'd3
    } status_t;

    // Classified command kinds handed from front to back.
    typedef enum logic [1:0] {
        K_TRANSLATE  = 2'd0,
        K_DIR_WRITE  = 2'd1,
        K_PAGE_WRITE = 2'd2,
        K_ACK        = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [VA_W-1:0]    virt_addr;
        logic               is_write;
        logic [INDEX_W-1:0] dir_index;
        logic [INDEX_W-1:0] table_index;
        logic [SLOT_W-1:0]  table_slot;
        logic               entry_present;
        logic               entry_writable;
        logic [FRAME_W-1:0] entry_frame;
    } in_item_t;

    typedef struct packed {
        status_t         status;
        logic [PA_W-1:0] phys_addr;
        logic            was_translation;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t kind;
        in_item_t  item;
    } cmd_t;

    // Stored directory entry.
    typedef struct packed {
        logic              present;
        logic [SLOT_W-1:0] slot;
    } dir_entry_t;

    // Stored page table entry.
    typedef struct packed {
        logic               present;
        logic               writable;
        logic [FRAME_W-1:0] frame;
    } page_entry_t;

endpackage

`default_nettype wire

### hw/rtl/two_level_page_translation.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_item (in_item_t)
// m_       out        m_valid / m_ready  m_item (out_item_t)
//
// One item per cycle sustained while m_ready is high; items pass the queue, s1, s2 and m_item.
// The front queue holds four items; the back is three stages around two registered RAM reads.
// After reset a clearing pass over max(2^DIR_INDEX_BITS, TABLE_POOL * 2^TABLE_INDEX_BITS)
// addresses (4096 at the defaults) zeroes both stores; s_ready stays low during it.
// A stall on m_ready freezes the back stages; the front keeps filling the queue.

module two_level_page_translation
    import tlpt_pkg::*;
#(
    parameter int DIR_INDEX_BITS   = 10,
    parameter int TABLE_INDEX_BITS = 10,
    parameter int PAGE_OFFSET_BITS = 12,
    parameter int TABLE_POOL       = 4
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_item
);

    logic clearing;
    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    // Front: accepts and classifies items.
    tlpt_front #(
        .TABLE_POOL (TABLE_POOL)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .clearing (clearing),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_cmd    (fq_cmd)
    );

    // Command queue between front and back.
    tlpt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // Back: table lookups, writes and result formation.
    tlpt_back #(
        .DIR_INDEX_BITS   (DIR_INDEX_BITS),
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
        .TABLE_POOL       (TABLE_POOL)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_cmd    (qb_cmd),
        .clearing (clearing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

`default_nettype wire

### hw/rtl/tlpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port; the read data holds while re is low.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/tlpt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tlpt_front
    import tlpt_pkg::*;
#(
    parameter int TABLE_POOL = 4
) (
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    input  wire logic     clearing,
    output logic          q_valid,
    input  wire logic     q_ready,
    output cmd_t          q_cmd
);

    logic slot_ok;

    // The front takes an item whenever the queue has room and the stores are ready.
    assign s_ready = q_ready && !clearing;
    assign q_valid = s_valid && !clearing;

    // A write to a slot beyond the pool becomes a plain acknowledge.
    assign slot_ok = 32'(s_item.table_slot) < TABLE_POOL;

    // Classify the item so the back end only has to look at the kind.
    always_comb begin
        q_cmd.item = s_item;
        case (s_item.op)
            OP_TRANSLATE:  q_cmd.kind = K_TRANSLATE;
            OP_WRITE_DIR:  q_cmd.kind = slot_ok ? K_DIR_WRITE : K_ACK;
            OP_WRITE_PAGE: q_cmd.kind = slot_ok ? K_PAGE_WRITE : K_ACK;
            OP_UNUSED:     q_cmd.kind = K_ACK;
            default:       q_cmd.kind = K_ACK;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/tlpt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tlpt_queue
    import tlpt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             fifo_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = fifo_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers wrap on their own since the depth is a power of two.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // The fill count never runs past the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // The count tracks the pointer distance whenever the queue is not full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CNT_W'(QUEUE_DEPTH)) || (PTR_W'(count_reg) == wr_ptr_reg - rd_ptr_reg))
        else $error("queue count and pointers disagree");

endmodule

`default_nettype wire

### hw/rtl/tlpt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tlpt_back
    import tlpt_pkg::*;
#(
    parameter int DIR_INDEX_BITS   = 10,
    parameter int TABLE_INDEX_BITS = 10,
    parameter int PAGE_OFFSET_BITS = 12,
    parameter int TABLE_POOL       = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire cmd_t q_cmd,
    output logic      clearing,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_item
);

    localparam int DIR_DEPTH  = 1 << DIR_INDEX_BITS;
    localparam int PAGE_DEPTH = TABLE_POOL << TABLE_INDEX_BITS;
    localparam int DIR_AW     = $clog2(DIR_DEPTH);
    localparam int PAGE_AW    = $clog2(PAGE_DEPTH);
    localparam int CLR_DEPTH  = (DIR_DEPTH > PAGE_DEPTH) ? DIR_DEPTH : PAGE_DEPTH;
    localparam int CLR_AW     = $clog2(CLR_DEPTH);
    localparam int DIR_W      = $bits(dir_entry_t);
    localparam int PAGE_W     = $bits(page_entry_t);

    // Clearing sequencer state.
    logic              clr_busy_reg;
    logic [CLR_AW-1:0] clr_cnt_reg;

    // Pipeline control and payload.
    logic                        advance;
    logic                        pop;
    logic                        s1_valid_reg;
    cmd_t                        s1_cmd_reg;
    logic                        s2_valid_reg;
    logic                        s2_translate_reg;
    logic                        s2_dir_ok_reg;
    logic                        s2_is_write_reg;
    logic [PAGE_OFFSET_BITS-1:0] s2_offset_reg;
    logic                        m_valid_reg;
    out_item_t                   m_item_reg;

    // Memory ports.
    logic               dir_we;
    logic [DIR_AW-1:0]  dir_waddr;
    dir_entry_t         dir_wdata;
    logic [DIR_AW-1:0]  dir_raddr;
    logic [DIR_W-1:0]   dir_rdata;
    dir_entry_t         dir_entry;
    logic               page_we;
    logic [PAGE_AW-1:0] page_waddr;
    page_entry_t        page_wdata;
    logic [PAGE_AW-1:0] page_raddr;
    logic [PAGE_W-1:0]  page_rdata;
    page_entry_t        page_entry;

    logic [63:0]        va_head;
    logic [63:0]        va_s1;
    logic               s1_dir_ok;
    out_item_t          result;
    logic [63:0]        pa_wide;

    // The whole pipeline moves when the output register is free or being emptied and no clearing runs.
    assign advance  = (!m_valid_reg || m_ready) && !clr_busy_reg;
    assign q_ready  = advance;
    assign pop      = advance && q_valid;
    assign clearing = clr_busy_reg;

    // Clearing pass after reset: both stores are zeroed one entry per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Directory access happens when an item leaves the queue.
    assign va_head   = 64'(q_cmd.item.virt_addr);
    assign dir_raddr = DIR_AW'(va_head >> (PAGE_OFFSET_BITS + TABLE_INDEX_BITS));

    always_comb begin
        if (clr_busy_reg) begin
            dir_we    = 1'b1;
            dir_waddr = DIR_AW'(clr_cnt_reg);
            dir_wdata = '0;
        end else begin
            dir_we            = pop && (q_cmd.kind == K_DIR_WRITE);
            dir_waddr         = DIR_AW'(q_cmd.item.dir_index);
            dir_wdata.present = q_cmd.item.entry_present;
            dir_wdata.slot    = q_cmd.item.table_slot;
        end
    end

    tlpt_ram #(
        .WIDTH (DIR_W),
        .DEPTH (DIR_DEPTH)
    ) u_dir_ram (
        .aclk  (aclk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (advance),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    // Page table access happens one stage later, in item order.
    assign dir_entry  = dir_entry_t'(dir_rdata);
    assign s1_dir_ok  = dir_entry.present && (32'(dir_entry.slot) < TABLE_POOL);
    assign va_s1      = 64'(s1_cmd_reg.item.virt_addr);
    assign page_raddr = PAGE_AW'({dir_entry.slot,
                                  TABLE_INDEX_BITS'(va_s1 >> PAGE_OFFSET_BITS)});

    always_comb begin
        if (clr_busy_reg) begin
            page_we    = 1'b1;
            page_waddr = PAGE_AW'(clr_cnt_reg);
            page_wdata = '0;
        end else begin
            page_we             = advance && s1_valid_reg
                                  && (s1_cmd_reg.kind == K_PAGE_WRITE);
            page_waddr          = PAGE_AW'({s1_cmd_reg.item.table_slot,
                                            TABLE_INDEX_BITS'(s1_cmd_reg.item.table_index)});
            page_wdata.present  = s1_cmd_reg.item.entry_present;
            page_wdata.writable = s1_cmd_reg.item.entry_writable;
            page_wdata.frame    = s1_cmd_reg.item.entry_frame;
        end
    end

    tlpt_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (PAGE_DEPTH)
    ) u_page_ram (
        .aclk  (aclk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (page_wdata),
        .re    (advance),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    // Fault checks in order: directory, page, protection.
    assign page_entry = page_entry_t'(page_rdata);
    assign pa_wide    = (64'(page_entry.frame) << PAGE_OFFSET_BITS) | 64'(s2_offset_reg);

    always_comb begin
        result.status          = ST_OK;
        result.phys_addr       = '0;
        result.was_translation = s2_translate_reg;
        if (s2_translate_reg) begin
            if (!s2_dir_ok_reg) begin
                result.status = ST_DIR_FAULT;
            end else if (!page_entry.present) begin
                result.status = ST_PAGE_FAULT;
            end else if (s2_is_write_reg && !page_entry.writable) begin
                result.status = ST_PROT_FAULT;
            end else begin
                result.phys_addr = pa_wide[PA_W-1:0];
            end
        end
    end

    // Stage valid bits and the output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg;
        end
    end

    // Stage payloads move with the valid bits.
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_cmd_reg       <= q_cmd;
            s2_translate_reg <= s1_cmd_reg.kind == K_TRANSLATE;
            s2_dir_ok_reg    <= s1_dir_ok;
            s2_is_write_reg  <= s1_cmd_reg.item.is_write;
            s2_offset_reg    <= PAGE_OFFSET_BITS'(s1_cmd_reg.item.virt_addr);
            m_item_reg       <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Nothing is in flight while the stores are being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> (!s1_valid_reg && !s2_valid_reg && !m_valid_reg))
        else $error("item in flight during clearing pass");

    // A write acknowledge never carries a fault or an address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_item_reg.was_translation)
        |-> (m_item_reg.status == ST_OK && m_item_reg.phys_addr == '0))
        else $error("write acknowledge carries translation data");

    // An item in the last stage reaches the output when the pipeline moves.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && advance) |=> m_valid_reg)
        else $error("item lost between page lookup and output");

    // Stores are never written by an item while the pipeline is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!clr_busy_reg && !advance) |-> (!dir_we && !page_we))
        else $error("store written during stall");

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import tlpt_pkg::*;

    // Block configuration as instantiated below (defaults).
    localparam int OFFSET_W     = 12;
    localparam int POOL_SLOTS   = 4;
    localparam int DIR_DEPTH    = 1 << INDEX_W;
    localparam int PAGE_DEPTH   = POOL_SLOTS << INDEX_W;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PERCENT = 6;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Shadow copy of the directory and the page table pool.
    logic               dir_present [DIR_DEPTH];
    logic [SLOT_W-1:0]  dir_slot    [DIR_DEPTH];
    page_entry_t        page_store  [PAGE_DEPTH];

    out_item_t answers_due [$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        no_idle     = 1'b0;

    two_level_page_translation DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Drive the result side ready and check every accepted result item.
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d pa %h tr %0d",
                         $time, m_item.status, m_item.phys_addr,
                         m_item.was_translation);
                error_count = error_count + 1;
            end else begin
                want = answers_due.pop_front();
                if (m_item.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_item.status);
                    error_count = error_count + 1;
                end
                if (m_item.phys_addr !== want.phys_addr) begin
                    $display("%0t: phys_addr mismatch, expected %h, actual %h",
                             $time, want.phys_addr, m_item.phys_addr);
                    error_count = error_count + 1;
                end
                if (m_item.was_translation !== want.was_translation) begin
                    $display("%0t: was_translation mismatch, expected %0d, actual %0d",
                             $time, want.was_translation, m_item.was_translation);
                    error_count = error_count + 1;
                end
            end
        end
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Apply one item to the shadow tables and return the answer it earns.
    function automatic out_item_t walk_tables(input in_item_t it);
        out_item_t         r;
        logic [INDEX_W-1:0] vd;
        logic [INDEX_W-1:0] vt;
        page_entry_t       pe;
        r.status          = ST_OK;
        r.phys_addr       = '0;
        r.was_translation = 1'b0;
        case (it.op)
            OP_TRANSLATE: begin
                r.was_translation = 1'b1;
                vd = it.virt_addr[OFFSET_W + 2*INDEX_W - 1 -: INDEX_W];
                vt = it.virt_addr[OFFSET_W + INDEX_W - 1 -: INDEX_W];
                if (!dir_present[vd]) begin
                    r.status = ST_DIR_FAULT;
                end else begin
                    pe = page_store[{dir_slot[vd], vt}];
                    if (!pe.present) begin
                        r.status = ST_PAGE_FAULT;
                    end else if (it.is_write && !pe.writable) begin
                        r.status = ST_PROT_FAULT;
                    end else begin
                        r.phys_addr = {pe.frame, it.virt_addr[OFFSET_W-1:0]};
                    end
                end
            end
            OP_WRITE_DIR: begin
                if (int'(it.table_slot) < POOL_SLOTS) begin
                    dir_present[it.dir_index] = it.entry_present;
                    dir_slot[it.dir_index]    = it.table_slot;
                end
            end
            OP_WRITE_PAGE: begin
                if (int'(it.table_slot) < POOL_SLOTS) begin
                    pe.present  = it.entry_present;
                    pe.writable = it.entry_writable;
                    pe.frame    = it.entry_frame;
                    page_store[{it.table_slot, it.table_index}] = pe;
                end
            end
            default: begin
                // The unused op only earns an acknowledge.
            end
        endcase
        return r;
    endfunction

    // Every field drawn over its whole range.
    function automatic in_item_t random_item();
        in_item_t it;
        it.op              = 2'($urandom_range(3));
        it.virt_addr       = $urandom;
        it.is_write        = 1'($urandom_range(1));
        it.dir_index       = INDEX_W'($urandom_range(DIR_DEPTH - 1));
        it.table_index     = INDEX_W'($urandom_range(DIR_DEPTH - 1));
        it.table_slot      = SLOT_W'($urandom_range(3));
        it.entry_present   = 1'($urandom_range(1));
        it.entry_writable  = 1'($urandom_range(1));
        it.entry_frame     = FRAME_W'($urandom_range((1 << FRAME_W) - 1));
        return it;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] op, input logic [VA_W-1:0] va,
                                           input logic wr, input logic [INDEX_W-1:0] di,
                                           input logic [INDEX_W-1:0] ti,
                                           input logic [SLOT_W-1:0] slot, input logic pres,
                                           input logic wbl, input logic [FRAME_W-1:0] frame);
        in_item_t it;
        it.op              = op;
        it.virt_addr       = va;
        it.is_write        = wr;
        it.dir_index       = di;
        it.table_index     = ti;
        it.table_slot      = slot;
        it.entry_present   = pres;
        it.entry_writable  = wbl;
        it.entry_frame     = frame;
        return it;
    endfunction

    // Offer one item, with an occasional idle gap first, and record its answer.
    task automatic send_item(input in_item_t it);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        answers_due.push_back(walk_tables(it));
    endtask

    // Field extremes, every op, acknowledges and each fault kind.
    task automatic test_corner_cases();
        send_item(make_item(OP_TRANSLATE, 32'h0000_0000, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0));
        send_item(make_item(OP_TRANSLATE, 32'hFFFF_FFFF, 1'b1, '1, '1, '1, 1'b1, 1'b1, '1));
        send_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, '1, '1, '1, 1'b1, 1'b1, '1));
        send_item(make_item(OP_UNUSED, 32'h0000_0000, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0));
        send_item(make_item(OP_WRITE_DIR, 32'hFFFF_FFFF, 1'b1, '1, '1, 2'd3, 1'b1, 1'b1, '1));
        send_item(make_item(OP_TRANSLATE, 32'hFFFF_FFFF, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0));
        send_item(make_item(OP_WRITE_PAGE, 32'h0, 1'b0, '0, '1, 2'd3, 1'b1, 1'b1, '1));
        send_item(make_item(OP_TRANSLATE, 32'hFFFF_FFFF, 1'b1, '0, '0, '0, 1'b0, 1'b0, '0));
        send_item(make_item(OP_TRANSLATE, 32'hFFC0_0000, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0));
        // A read-only page with frame zero in the same slot.
        send_item(make_item(OP_WRITE_PAGE, 32'hFFFF_FFFF, 1'b1, '1, '1, 2'd3, 1'b1, 1'b0, '0));
        send_item(make_item(OP_TRANSLATE, 32'hFFFF_F123, 1'b1, '0, '0, '0, 1'b0, 1'b0, '0));
        send_item(make_item(OP_TRANSLATE, 32'hFFFF_F000, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0));
        send_item(make_item(OP_WRITE_DIR, 32'h0, 1'b0, '0, '0, 2'd0, 1'b1, 1'b0, '0));
        send_item(make_item(OP_WRITE_PAGE, 32'h0, 1'b0, '0, '0, 2'd0, 1'b1, 1'b1, 20'hABCDE));
        send_item(make_item(OP_TRANSLATE, 32'h0000_0FFF, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0));
        // A page that is writable but not present still faults.
        send_item(make_item(OP_WRITE_PAGE, 32'h0, 1'b0, '0, '0, 2'd0, 1'b0, 1'b1, '1));
        send_item(make_item(OP_TRANSLATE, 32'h0000_0000, 1'b1, '0, '0, '0, 1'b0, 1'b0, '0));
        send_item(make_item(OP_WRITE_DIR, 32'h0, 1'b0, '0, '0, 2'd3, 1'b0, 1'b0, '0));
        send_item(make_item(OP_TRANSLATE, 32'h0000_0000, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0));
        // Repoint directory entry zero at the last slot.
        send_item(make_item(OP_WRITE_DIR, 32'h0, 1'b0, '0, '0, 2'd3, 1'b1, 1'b0, '0));
        send_item(make_item(OP_TRANSLATE, 32'h003F_F000, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0));
        send_item(make_item(OP_TRANSLATE, 32'h003F_FFFF, 1'b1, '0, '0, '0, 1'b0, 1'b0, '0));
    endtask

    // Map a few pages, then translate mostly into them right behind the writes.
    task automatic test_table_walks(input int rounds);
        logic [INDEX_W-1:0] hot_dir [4];
        logic [INDEX_W-1:0] hot_tab [4];
        logic [SLOT_W-1:0]  slot;
        in_item_t           it;
        for (int k = 0; k < 4; k++) begin
            hot_dir[k] = INDEX_W'($urandom_range(DIR_DEPTH - 1));
            hot_tab[k] = INDEX_W'($urandom_range(DIR_DEPTH - 1));
        end
        repeat (rounds) begin
            // Drift the hot set slowly so old mappings are revisited too.
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(2) == 0) hot_dir[k] = INDEX_W'($urandom_range(DIR_DEPTH - 1));
                if ($urandom_range(2) == 0) hot_tab[k] = INDEX_W'($urandom_range(DIR_DEPTH - 1));
            end
            slot = SLOT_W'($urandom_range(3));

            it               = random_item();
            it.op            = OP_WRITE_DIR;
            it.dir_index     = hot_dir[$urandom_range(3)];
            it.table_slot    = slot;
            it.entry_present = ($urandom_range(9) != 0);
            send_item(it);

            repeat (3) begin
                it               = random_item();
                it.op            = OP_WRITE_PAGE;
                it.table_index   = hot_tab[$urandom_range(3)];
                if ($urandom_range(4) != 0) it.table_slot = slot;
                it.entry_present = ($urandom_range(7) != 0);
                send_item(it);
            end

            repeat (6) begin
                it    = random_item();
                it.op = OP_TRANSLATE;
                if ($urandom_range(7) != 0) begin
                    it.virt_addr = {hot_dir[$urandom_range(3)], hot_tab[$urandom_range(3)],
                                    OFFSET_W'($urandom_range((1 << OFFSET_W) - 1))};
                end
                send_item(it);
            end
        end
    endtask

    // The same walks with both sides never idling.
    task automatic test_unbroken_burst(input int rounds);
        no_idle = 1'b1;
        test_table_walks(rounds);
        no_idle = 1'b0;
    endtask

    // Fully random items, including the unused op.
    task automatic test_random_noise(input int count);
        repeat (count) send_item(random_item());
    endtask

    initial begin
        for (int i = 0; i < DIR_DEPTH; i++) begin
            dir_present[i] = 1'b0;
            dir_slot[i]    = '0;
        end
        for (int i = 0; i < PAGE_DEPTH; i++) page_store[i] = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_corner_cases();
        test_table_walks(60);
        test_unbroken_burst(20);
        test_random_noise(300);
        test_table_walks(30);

        // Drop valid right at the edge that took the last item.
        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
